// ===== sv/ksel_pkg.sv =====
// Shared types, constants and helpers for the k-th name selector.
// No dependencies; imported by every module of the block except ksel_ram.
`default_nettype none

package ksel_pkg;

    localparam int LETTER_BITS    = 5;
    localparam int HALF_LETTERS   = 10;
    localparam int HALF_BITS      = LETTER_BITS * HALF_LETTERS;
    localparam int NAME_BITS      = 2 * HALF_BITS;
    localparam int RANK_W         = 8;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 3;

    localparam int MAX_NAMES_DEF  = 128;
    localparam int NAME_CHARS_DEF = 20;

    // Register index, taken from paddr[2]
    localparam logic REG_RANK = 1'b0;
    localparam logic [RANK_W-1:0] RANK_RESET = 8'd1;

    typedef struct packed {
        logic [HALF_BITS-1:0] name_first_half;
        logic [HALF_BITS-1:0] name_second_half;
        logic                 is_last;
    } name_word_t;

    typedef struct packed {
        logic [HALF_BITS-1:0] winner_first_half;
        logic [HALF_BITS-1:0] winner_second_half;
        logic                 rank_error;
        logic                 overflow_seen;
    } result_word_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_en;    // input side open
        logic sel_start;  // first candidate
        logic rd_cand;    // address store with candidate index
        logic cand_cap;   // capture candidate, clear scan
        logic scan;       // walk the store
        logic next_cand;  // candidate missed, step on
        logic take_win;   // candidate is the winner
        logic take_error; // rank out of range
        logic publish;    // load output register, end the run
    } ksel_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic rank_ok;
        logic scan_done;
        logic hit;
        logic out_free;
    } ksel_status_t;

    // Keeps the letter slots of one half that lie below the name length limit
    function automatic logic [HALF_BITS-1:0] keep_mask(input int first, input int chars);
        logic [HALF_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < HALF_LETTERS; i++)
        begin
            if (first + i < chars)
            begin
                m[HALF_BITS-1-LETTER_BITS*i -: LETTER_BITS] = '1;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ksel_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module ksel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/ksel_dp.sv =====
// Datapath of the k-th name selector: name store, run count, scan counters,
// candidate compare and output register. Depends on ksel_pkg and ksel_ram.
`default_nettype none

module ksel_dp
    import ksel_pkg::*;
#(
    parameter int MAX_NAMES  = MAX_NAMES_DEF,
    parameter int NAME_CHARS = NAME_CHARS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ksel_cmd_t    cmd,
    output ksel_status_t      status,
    input  wire logic [RANK_W-1:0] rank,
    input  wire logic         name_valid,
    input  wire name_word_t   name,
    output logic              result_valid,
    input  wire logic         result_ready,
    output result_word_t      result
);

    localparam int AW   = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1;
    localparam int CW   = $clog2(MAX_NAMES + 1);
    localparam int KW   = ((CW > RANK_W) ? CW : RANK_W) + 1;
    localparam logic [HALF_BITS-1:0] KEEP_HI = keep_mask(0, NAME_CHARS);
    localparam logic [HALF_BITS-1:0] KEEP_LO = keep_mask(HALF_LETTERS, NAME_CHARS);
    localparam logic [CW-1:0] FULL = CW'(MAX_NAMES);

    logic [CW-1:0]        count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic [AW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic                 cmp_v_reg, cmp_v_next;
    logic [NAME_BITS-1:0] cand_reg, cand_next;
    logic [CW-1:0]        below_reg, below_next;
    logic [CW-1:0]        same_reg, same_next;
    logic [NAME_BITS-1:0] win_reg, win_next;
    logic                 err_reg, err_next;
    logic                 out_valid_reg, out_valid_next;
    result_word_t         out_reg, out_next;

    logic                 load_word;
    logic                 wr_en;
    logic [NAME_BITS-1:0] wr_data;
    logic [AW-1:0]        rd_addr;
    logic [NAME_BITS-1:0] rd_data;
    logic [KW-1:0]        k_ext, below_ext, upper_ext, count_ext;

    assign load_word = cmd.load_en && name_valid;
    assign wr_en     = load_word && (count_reg != FULL);
    assign wr_data   = {name.name_first_half & KEEP_HI, name.name_second_half & KEEP_LO};
    assign rd_addr   = cmd.rd_cand ? i_reg : j_reg[AW-1:0];

    ksel_ram #(
        .WIDTH (NAME_BITS),
        .DEPTH (MAX_NAMES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign k_ext     = KW'(rank);
    assign below_ext = KW'(below_reg);
    assign upper_ext = KW'(below_reg) + KW'(same_reg);
    assign count_ext = KW'(count_reg);

    assign status.rank_ok   = (rank != '0) && (k_ext <= count_ext);
    assign status.scan_done = (j_reg == count_reg) && !cmp_v_reg;
    assign status.hit       = (below_ext < k_ext) && (k_ext <= upper_ext);
    assign status.out_free  = !out_valid_reg || result_ready;

    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cmp_v_next     = cmp_v_reg;
        cand_next      = cand_reg;
        below_next     = below_reg;
        same_next      = same_reg;
        win_next       = win_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;

        if (load_word)
        begin
            if (count_reg != FULL)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end

        if (cmd.sel_start)
        begin
            i_next = '0;
        end
        if (cmd.next_cand)
        begin
            i_next = i_reg + AW'(1);
        end

        if (cmd.cand_cap)
        begin
            cand_next  = rd_data;
            j_next     = '0;
            cmp_v_next = 1'b0;
            below_next = '0;
            same_next  = '0;
        end

        if (cmd.scan)
        begin
            if (cmp_v_reg)
            begin
                if (rd_data < cand_reg)
                begin
                    below_next = below_reg + CW'(1);
                end
                else if (rd_data == cand_reg)
                begin
                    same_next = same_reg + CW'(1);
                end
            end
            if (j_reg != count_reg)
            begin
                j_next     = j_reg + CW'(1);
                cmp_v_next = 1'b1;
            end
            else
            begin
                cmp_v_next = 1'b0;
            end
        end

        if (cmd.take_win)
        begin
            win_next = cand_reg;
            err_next = 1'b0;
        end
        if (cmd.take_error)
        begin
            win_next = '0;
            err_next = 1'b1;
        end

        if (cmd.publish)
        begin
            out_next.winner_first_half  = win_reg[NAME_BITS-1:HALF_BITS];
            out_next.winner_second_half = win_reg[HALF_BITS-1:0];
            out_next.rank_error         = err_reg;
            out_next.overflow_seen      = dropped_reg;
            out_valid_next              = 1'b1;
            count_next                  = '0;
            dropped_next                = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            cmp_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            cmp_v_reg     <= cmp_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        cand_reg  <= cand_next;
        below_reg <= below_next;
        same_reg  <= same_next;
        win_reg   <= win_next;
        err_reg   <= err_next;
        out_reg   <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ===== sv/ksel_ctrl.sv =====
// Controller of the k-th name selector: sequences loading, candidate scans
// and result hand-off. Depends on ksel_pkg.
`default_nettype none

module ksel_ctrl
    import ksel_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         name_valid,
    input  wire logic         name_last,
    input  wire ksel_status_t status,
    output ksel_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_CAND_RD,
        ST_CAND_CAP,
        ST_SCAN,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load_en = 1'b1;
                if (name_valid && name_last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.rank_ok)
                begin
                    cmd.sel_start = 1'b1;
                    state_next    = ST_CAND_RD;
                end
                else
                begin
                    cmd.take_error = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_CAND_RD:
            begin
                cmd.rd_cand = 1'b1;
                state_next  = ST_CAND_CAP;
            end
            ST_CAND_CAP:
            begin
                cmd.cand_cap = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (status.hit)
                begin
                    cmd.take_win = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmd.next_cand = 1'b1;
                    state_next    = ST_CAND_RD;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/kth_name_in_sorted_order.sv =====
// Throughput: name words are taken one per cycle while a set is loading.
// Selection: after the word marked last, each candidate is compared against
// every stored name through the single read port of the name store, one
// read per cycle.
// Reset: asynchronous, active low; clears count, overflow flag and output
// valid, and sets the rank register to 1. The name store itself is not cleared.
`default_nettype none

module kth_name_in_sorted_order
    import ksel_pkg::*;
#(
    parameter int MAX_NAMES  = MAX_NAMES_DEF,
    parameter int NAME_CHARS = NAME_CHARS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    // name input channel
    input  wire logic              name_valid,
    output logic                   name_ready,
    input  wire name_word_t        name,

    // result channel
    output logic                   result_valid,
    input  wire logic              result_ready,
    output result_word_t           result,

    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    ksel_cmd_t    cmd;
    ksel_status_t status;

    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              rank_wr;

    // Register block: a single 8-bit rank register at byte address 0.
    // Writes are to be made only between runs; the block does not enforce this.
    assign pready  = 1'b1;
    assign rank_wr = psel && penable && pwrite && (paddr[2] == REG_RANK);

    always_comb
    begin
        rank_next = rank_reg;
        if (rank_wr)
        begin
            rank_next = pwdata[RANK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= RANK_RESET;
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    assign prdata = (paddr[2] == REG_RANK) ? DATA_W'(rank_reg) : '0;

    // Input side is open only while loading; the output register lets the
    // next set load while the previous result still waits to be taken.
    assign name_ready = cmd.load_en;

    ksel_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .name_valid (name_valid),
        .name_last  (name.is_last),
        .status     (status),
        .cmd        (cmd)
    );

    ksel_dp #(
        .MAX_NAMES  (MAX_NAMES),
        .NAME_CHARS (NAME_CHARS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .rank         (rank_reg),
        .name_valid   (name_valid),
        .name         (name),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== sv/ksel_chk.sv =====
// Port-level checks for the k-th name selector, bound to the top level.
// Depends on ksel_pkg and kth_name_in_sorted_order.
`default_nettype none

module ksel_chk
    import ksel_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              name_valid,
    input wire logic              name_ready,
    input wire name_word_t        name,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire result_word_t      result,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [DATA_W-1:0] pwdata,
    input wire logic [DATA_W-1:0] prdata,
    input wire logic              pready
);

    // Held result word must not move
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // A rank error carries an all-zero winner
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.rank_error |->
            (result.winner_first_half == '0) && (result.winner_second_half == '0))
        else $error("rank error with non-zero winner");

    // Input closes once the last word of a set is taken
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        name_valid && name_ready && name.is_last |=> !name_ready)
        else $error("input still open after last word");

    // Rank register reads back what was written
    a_rank_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_RANK) |=>
            (paddr[2] != REG_RANK) || (prdata == DATA_W'($past(pwdata[RANK_W-1:0]))))
        else $error("rank register readback mismatch");

endmodule

bind kth_name_in_sorted_order ksel_chk u_chk (.*);

`default_nettype wire
